@@ sv/moving_average_filter_top_macros.svh @@
// ---------------------------------------------------------------------------
// moving_average_filter_top_macros.svh
// Assertion macros used by the filter top level.
// ---------------------------------------------------------------------------
`ifndef MOVING_AVERAGE_FILTER_TOP_MACROS_SVH
`define MOVING_AVERAGE_FILTER_TOP_MACROS_SVH

// Condition must never be true outside reset.
`define MAF_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

// Antecedent in one cycle requires consequent in the next cycle.
`define MAF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/maf_pkg.sv @@
// ---------------------------------------------------------------------------
// maf_pkg
// Shared constants, widths and controller/datapath interface types for the
// moving average filter.
// ---------------------------------------------------------------------------
package maf_pkg;

    // Ring depth, range 1 to 4
    localparam int TAPS        = 4;
    localparam int SAMPLE_W    = 16;
    localparam int WEIGHT_W    = 16;
    localparam int FRAC_W      = 14;
    localparam int NUM_WEIGHTS = 4;
    localparam int WIDX_W      = $clog2(NUM_WEIGHTS);

    localparam int POS_W   = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int TOT_W   = SAMPLE_W + POS_W;
    localparam int MAG_W   = TOT_W;
    localparam int DIV_S   = TOT_W;
    localparam int RECIP_W = TOT_W;
    localparam int DPROD_W = MAG_W + RECIP_W;
    localparam int PROD_W  = SAMPLE_W + WEIGHT_W;
    localparam int ACC_W   = PROD_W + POS_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [POS_W-1:0]          TAPS_LAST = POS_W'(TAPS - 1);
    localparam logic signed [TOT_W-1:0]   TAPS_TOT  = TOT_W'(TAPS);
    localparam logic [MAG_W-1:0]          TAPS_MAG  = MAG_W'(TAPS);
    // Reciprocal of TAPS, floored, for a quotient that is exact or one low
    localparam logic [RECIP_W-1:0]        RECIP     = RECIP_W'(((1 << DIV_S) - 1) / TAPS);
    localparam logic signed [ACC_W-1:0]   SAT_HI    = ACC_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0]   SAT_LO    = ACC_W'(-(1 << (SAMPLE_W - 1)));
    localparam logic signed [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(4096);

    // Request types of an input beat
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_FILL   = 1'b1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE     = 3'd0,
        CFG_WEIGHT_0 = 3'd1,
        CFG_WEIGHT_1 = 3'd2,
        CFG_WEIGHT_2 = 3'd3,
        CFG_WEIGHT_3 = 3'd4
    } t_cfg_idx;

    // Result source
    typedef enum logic [1:0] {
        RES_INIT = 2'd0,
        RES_WSAT = 2'd1,
        RES_AVG  = 2'd2
    } t_res_sel;

    typedef struct packed {
        logic     load;
        logic     mac_step;
        logic     acc_add;
        logic     div_abs;
        logic     div_mul;
        logic     result_we;
        t_res_sel result_sel;
    } t_ctrl_cmd;

    typedef struct packed {
        logic weighted_mode;
        logic out_valid;
    } t_dp_stat;

endpackage

@@ sv/maf_ctrl.sv @@
// ---------------------------------------------------------------------------
// maf_ctrl
// Sequencer for the filter: accepts a beat, walks the weighted MAC or the
// divide steps (not for fills) and writes the result to the output register.
// ---------------------------------------------------------------------------
module maf_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_req_type,
    output logic               o_in_ready,
    input  logic               i_out_ready,
    input  maf_pkg::t_dp_stat  i_stat,
    output maf_pkg::t_ctrl_cmd o_cmd
);
    import maf_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_INIT_OUT = 8'b0000_0010,
        ST_MAC      = 8'b0000_0100,
        ST_MAC_END  = 8'b0000_1000,
        ST_SAT      = 8'b0001_0000,
        ST_DIV_ABS  = 8'b0010_0000,
        ST_DIV_MUL  = 8'b0100_0000,
        ST_DIV_FIX  = 8'b1000_0000
    } t_state;

    t_state             r_state, n_state;
    logic [POS_W-1:0]   r_cnt, n_cnt;
    logic               w_slot_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_slot_free = !i_stat.out_valid || i_out_ready;

    // Next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    if (i_req_type == REQ_FILL) begin
                        n_state = ST_INIT_OUT;
                    end else if (i_stat.weighted_mode) begin
                        n_state = ST_MAC;
                    end else begin
                        n_state = ST_DIV_ABS;
                    end
                end
            end
            ST_INIT_OUT: begin
                o_cmd.result_sel = RES_INIT;
                if (w_slot_free) begin
                    o_cmd.result_we = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            ST_MAC: begin
                // issue one product per cycle, add the previous one
                o_cmd.mac_step = 1'b1;
                o_cmd.acc_add  = (r_cnt != '0);
                if (r_cnt == TAPS_LAST) begin
                    n_state = ST_MAC_END;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_MAC_END: begin
                o_cmd.acc_add = 1'b1;
                n_state       = ST_SAT;
            end
            ST_SAT: begin
                o_cmd.result_sel = RES_WSAT;
                if (w_slot_free) begin
                    o_cmd.result_we = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            ST_DIV_ABS: begin
                o_cmd.div_abs = 1'b1;
                n_state       = ST_DIV_MUL;
            end
            ST_DIV_MUL: begin
                o_cmd.div_mul = 1'b1;
                n_state       = ST_DIV_FIX;
            end
            ST_DIV_FIX: begin
                o_cmd.result_sel = RES_AVG;
                if (w_slot_free) begin
                    o_cmd.result_we = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

@@ sv/maf_datapath.sv @@
// ---------------------------------------------------------------------------
// maf_datapath
// Sample ring, running total, weight registers, shared MAC, reciprocal
// divider and output register of the filter.
// ---------------------------------------------------------------------------
module maf_datapath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  maf_pkg::t_ctrl_cmd                     i_cmd,
    output maf_pkg::t_dp_stat                      o_stat,
    input  logic                                   i_req_type,
    input  logic signed [maf_pkg::SAMPLE_W-1:0]    i_sample_value,
    input  logic                                   i_out_ready,
    output logic                                   o_out_valid,
    output logic signed [maf_pkg::SAMPLE_W-1:0]    o_filtered_value,
    input  logic                                   i_cfg_we,
    input  logic [maf_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [maf_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import maf_pkg::*;

    logic                       r_mode;
    logic signed [WEIGHT_W-1:0] r_weight [NUM_WEIGHTS];
    logic signed [SAMPLE_W-1:0] r_ring [TAPS];
    logic [POS_W-1:0]           r_pos;
    logic signed [TOT_W-1:0]    r_total;
    logic [POS_W-1:0]           r_rd;
    logic [WIDX_W-1:0]          r_widx;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic [MAG_W-1:0]           r_mag;
    logic                       r_neg;
    logic [DPROD_W-1:0]         r_dprod;
    logic                       r_out_vld;
    logic signed [SAMPLE_W-1:0] r_out_data;

    logic [CFG_IDX_W-1:0]       w_cfg_off;
    logic signed [TOT_W-1:0]    w_val_ext, w_old_ext, w_fill_total, w_total_upd;
    logic [POS_W-1:0]           w_pos_next, w_rd_next;
    logic signed [ACC_W-1:0]    w_prod_ext, w_shift;
    logic signed [SAMPLE_W-1:0] w_sat;
    logic [MAG_W-1:0]           w_q0, w_q0_x, w_rem, w_q, w_avg;
    logic signed [SAMPLE_W-1:0] w_result;

    // Configuration registers
    assign w_cfg_off = i_cfg_idx - CFG_IDX_W'(CFG_WEIGHT_0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            for (int i = 0; i < NUM_WEIGHTS; i++) begin
                r_weight[i] <= WEIGHT_RESET;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_MODE) begin
                r_mode <= i_cfg_data[0];
            end else if (i_cfg_idx inside {[CFG_WEIGHT_0:CFG_WEIGHT_3]}) begin
                r_weight[w_cfg_off[WIDX_W-1:0]] <= i_cfg_data;
            end
        end
    end

    // Ring and running total update
    assign w_val_ext    = $signed({{POS_W{i_sample_value[SAMPLE_W-1]}}, i_sample_value});
    assign w_old_ext    = $signed({{POS_W{r_ring[r_pos][SAMPLE_W-1]}}, r_ring[r_pos]});
    assign w_fill_total = w_val_ext * TAPS_TOT;
    assign w_total_upd  = r_total - w_old_ext + w_val_ext;
    assign w_pos_next   = (r_pos == TAPS_LAST) ? '0 : r_pos + 1'b1;
    assign w_rd_next    = (r_rd == TAPS_LAST) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAPS; i++) begin
                r_ring[i] <= '0;
            end
            r_pos   <= '0;
            r_total <= '0;
            r_rd    <= '0;
            r_widx  <= '0;
        end else if (i_cmd.load) begin
            r_widx <= '0;
            if (i_req_type == REQ_FILL) begin
                for (int i = 0; i < TAPS; i++) begin
                    r_ring[i] <= i_sample_value;
                end
                r_total <= w_fill_total;
                r_pos   <= '0;
                r_rd    <= '0;
            end else begin
                r_ring[r_pos] <= i_sample_value;
                r_total       <= w_total_upd;
                r_pos         <= w_pos_next;
                // oldest entry sits at the new write position
                r_rd          <= w_pos_next;
            end
        end else if (i_cmd.mac_step) begin
            r_rd   <= w_rd_next;
            r_widx <= r_widx + 1'b1;
        end
    end

    // Weighted MAC: one product per cycle, registered before it is accumulated
    assign w_prod_ext = $signed({{POS_W{r_prod[PROD_W-1]}}, r_prod});

    always_ff @(posedge i_clk) begin
        if (i_cmd.mac_step) begin
            r_prod <= r_ring[r_rd] * r_weight[r_widx];
        end
        if (i_cmd.load) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + w_prod_ext;
        end
    end

    // Floor shift and saturate the weighted sum
    assign w_shift = r_acc >>> FRAC_W;

    always_comb begin
        if (w_shift > SAT_HI) begin
            w_sat = SAT_HI[SAMPLE_W-1:0];
        end else if (w_shift < SAT_LO) begin
            w_sat = SAT_LO[SAMPLE_W-1:0];
        end else begin
            w_sat = w_shift[SAMPLE_W-1:0];
        end
    end

    // Divide by TAPS: magnitude, reciprocal multiply, one correction step
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_abs) begin
            r_neg <= r_total[TOT_W-1];
            r_mag <= r_total[TOT_W-1] ? MAG_W'(-r_total) : MAG_W'(r_total);
        end
        if (i_cmd.div_mul) begin
            r_dprod <= r_mag * RECIP;
        end
    end

    assign w_q0   = r_dprod[DPROD_W-1:DIV_S];
    assign w_q0_x = w_q0 * TAPS_MAG;
    assign w_rem  = r_mag - w_q0_x;
    assign w_q    = (w_rem >= TAPS_MAG) ? w_q0 + 1'b1 : w_q0;
    assign w_avg  = r_neg ? (~w_q + 1'b1) : w_q;

    // Result select
    always_comb begin
        case (i_cmd.result_sel)
            RES_INIT: w_result = r_ring[0];
            RES_WSAT: w_result = w_sat;
            RES_AVG:  w_result = $signed(w_avg[SAMPLE_W-1:0]);
            default:  w_result = r_ring[0];
        endcase
    end

    // Output register: hold the beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.result_we) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.result_we) begin
            r_out_data <= w_result;
        end
    end

    assign o_out_valid          = r_out_vld;
    assign o_filtered_value     = r_out_data;
    assign o_stat.weighted_mode = r_mode;
    assign o_stat.out_valid     = r_out_vld;

endmodule

@@ sv/moving_average_filter_top.sv @@
// ---------------------------------------------------------------------------
// moving_average_filter_top
// Arithmetic or Q2.14 weighted moving average over a ring of TAPS samples.
//
//   channel  dir  handshake                  payload
//   in       in   i_in_valid / o_in_ready    i_req_type, i_sample_value
//   out      out  o_out_valid / i_out_ready  o_filtered_value
//   cfg      in   i_cfg_we                   i_cfg_idx, i_cfg_data
//
// A fill item goes straight to the output; an average takes magnitude,
// reciprocal multiply and correction steps; a weighted sum uses one shared
// 16x16 multiplier, one product per cycle. One item is in work at a time.
// Reset (synchronous, active low) empties the ring to zero, weights to 4096.
// A result waits in the output register; a new beat is taken meanwhile, and
// the sequencer stalls at its final step only while that register is full.
// ---------------------------------------------------------------------------
`include "moving_average_filter_top_macros.svh"

module moving_average_filter_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic                                i_req_type,
    input  logic signed [maf_pkg::SAMPLE_W-1:0] i_sample_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [maf_pkg::SAMPLE_W-1:0] o_filtered_value,
    input  logic                                i_cfg_we,
    input  logic [maf_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [maf_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import maf_pkg::*;

    t_ctrl_cmd w_cmd;
    t_dp_stat  w_stat;

    // Sequencer
    maf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_req_type),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Datapath
    maf_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_req_type       (i_req_type),
        .i_sample_value   (i_sample_value),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_filtered_value (o_filtered_value),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data)
    );

    // Checks
    `MAF_ASSERT_NEXT(a_busy_after_accept, i_in_valid && o_in_ready, !o_in_ready, "ready after accept")
    `MAF_ASSERT_NEVER(a_load_on_accept, w_cmd.load != (i_in_valid && o_in_ready), "load mismatch")
    `MAF_ASSERT_NEVER(a_no_overwrite, w_cmd.result_we && o_out_valid && !i_out_ready, "result lost")
    `MAF_ASSERT_NEXT(a_result_shown, w_cmd.result_we, o_out_valid, "result not presented")

endmodule
